FILE: rtl/voxel_ray_traversal_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the voxel ray traversal block
// Clocked implication checks used by the design file that asserts.
// ---------------------------------------------------------------------------
`ifndef VOXEL_RAY_TRAVERSAL_DEFINES_SVH
`define VOXEL_RAY_TRAVERSAL_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define VRT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("voxel ray traversal check failed");

// Next-cycle implication, disabled while reset is asserted
`define VRT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("voxel ray traversal check failed");

`endif

FILE: rtl/vrt_pkg.sv
// ---------------------------------------------------------------------------
// vrt_pkg
// Shared constants and types of the voxel ray traversal block.
// ---------------------------------------------------------------------------
package vrt_pkg;

    // Grid side is 2^GRID_BITS voxels
    localparam int GRID_BITS = 5;
    localparam int ROW_W     = 2 * GRID_BITS;
    localparam int POS_W     = 16;

    localparam logic [31:0] T_INF      = 32'hFFFF_FFFF;
    localparam logic [31:0] LEN_MIN_SQ = 32'd10;

    // Request opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST  = 1'b1;

    // Entry face codes
    localparam logic [2:0] FACE_START = 3'd0;
    localparam logic [2:0] FACE_PX    = 3'd1;
    localparam logic [2:0] FACE_NX    = 3'd2;
    localparam logic [2:0] FACE_PY    = 3'd3;
    localparam logic [2:0] FACE_NY    = 3'd4;
    localparam logic [2:0] FACE_PZ    = 3'd5;
    localparam logic [2:0] FACE_NZ    = 3'd6;

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_SQ    = 9'b000000100,
        S_SQRT  = 9'b000001000,
        S_DIV   = 9'b000010000,
        S_XMUL  = 9'b000100000,
        S_WREAD = 9'b001000000,
        S_WSTEP = 9'b010000000,
        S_SPARE = 9'b100000000
    } state_t;

endpackage

FILE: rtl/voxel_ray_traversal.sv
// ---------------------------------------------------------------------------
// voxel_ray_traversal
// Voxel grid ray caster: occupancy grid with a shared-unit sequencer.
// ---------------------------------------------------------------------------
// After reset the block clears all 2^(2*GRID_BITS) grid rows (1024 at the
// default size) one row a cycle with busy high. A write request returns
// nothing and leaves busy low. A cast request returns exactly one result,
// pulsed on done for a single cycle; the receiver cannot stall it, so it
// must sample it then. A cast sums the squares, takes the square root,
// divides once per nonzero direction axis (skipping zero axes), forms the
// first crossings, then reads the grid and steps per visited voxel.
// The shared multiplier, the one-bit-a-cycle divider and the single grid
// read port set the cost of these steps.
`include "voxel_ray_traversal_defines.svh"

module voxel_ray_traversal
    import vrt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                op,
    input  logic [4:0]          cell_x,
    input  logic [4:0]          cell_y,
    input  logic [4:0]          cell_z,
    input  logic                solid,
    input  logic signed [23:0]  origin_x,
    input  logic signed [23:0]  origin_y,
    input  logic signed [23:0]  origin_z,
    input  logic signed [15:0]  dir_x,
    input  logic signed [15:0]  dir_y,
    input  logic signed [15:0]  dir_z,
    input  logic [15:0]         max_dist,
    output logic                done,
    output logic                hit_found,
    output logic [4:0]          hit_x,
    output logic [4:0]          hit_y,
    output logic [4:0]          hit_z,
    output logic [2:0]          entry_face
);

    state_t state_reg, state_next;

    logic signed [15:0] d_reg [3];
    logic signed [15:0] d_next [3];
    logic [15:0] frac_reg [3];
    logic [15:0] frac_next [3];
    logic signed [POS_W-1:0] pos_reg [3];
    logic signed [POS_W-1:0] pos_next [3];
    logic [31:0] spc_reg [3];
    logic [31:0] spc_next [3];
    logic [31:0] crs_reg [3];
    logic [31:0] crs_next [3];

    logic [15:0] limit_reg, limit_next;
    logic [31:0] acc_reg, acc_next;
    logic [33:0] sv_reg, sv_next;
    logic [18:0] rem_reg, rem_next;
    logic [16:0] root_reg, root_next;
    logic [16:0] len_reg, len_next;
    logic [31:0] num_reg, num_next;
    logic [15:0] drem_reg, drem_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [1:0]  ax_reg, ax_next;
    logic [31:0] trav_reg, trav_next;
    logic [2:0]  face_reg, face_next;
    logic [ROW_W-1:0] clr_reg, clr_next;

    logic        done_reg, done_next;
    logic        hit_reg, hit_next;
    logic [4:0]  hx_reg, hx_next;
    logic [4:0]  hy_reg, hy_next;
    logic [4:0]  hz_reg, hz_next;
    logic [2:0]  hf_reg, hf_next;

    logic [48:0] prod_reg;
    logic [16:0] mul_a;
    logic [31:0] mul_b;
    logic [1:0]  sel;
    logic [1:0]  cm1;

    // Occupancy grid: one row of x voxels per (z, y)
    logic [(1 << GRID_BITS)-1:0] grid_mem [1 << ROW_W];
    logic [(1 << GRID_BITS)-1:0] row_reg;

    logic              accept;
    logic              wr_en;
    logic [POS_W-1:0]  cx_ext, cy_ext, cz_ext;
    logic [ROW_W-1:0]  rd_addr;

    logic [20:0] rt_sh, rt_t;
    logic        rt_ge;
    logic [16:0] dv_sh;
    logic [15:0] den;
    logic        dv_ge;
    logic [31:0] dv_num;
    logic        in_grid;
    logic        cell_hit;
    logic [1:0]  pick;
    logic [32:0] crs_sum;
    logic [31:0] limit_q;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);
    assign cx_ext = POS_W'(cell_x);
    assign cy_ext = POS_W'(cell_y);
    assign cz_ext = POS_W'(cell_z);
    assign wr_en  = accept && (op == OP_WRITE)
                    && ((cx_ext >> GRID_BITS) == '0)
                    && ((cy_ext >> GRID_BITS) == '0)
                    && ((cz_ext >> GRID_BITS) == '0);
    assign rd_addr = {pos_reg[2][GRID_BITS-1:0], pos_reg[1][GRID_BITS-1:0]};
    assign limit_q = {8'd0, limit_reg, 8'd0};

    // Clear, write and read the grid
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR)
        begin
            grid_mem[clr_reg] <= '0;
        end
        else if (wr_en)
        begin
            grid_mem[{cz_ext[GRID_BITS-1:0], cy_ext[GRID_BITS-1:0]}]
                [cx_ext[GRID_BITS-1:0]] <= solid;
        end
        row_reg <= grid_mem[rd_addr];
    end

    // Shared multiplier operand select
    assign sel = (cnt_reg[1:0] == 2'd3) ? 2'd0 : cnt_reg[1:0];
    assign cm1 = 2'(cnt_reg[1:0] - 2'd1);

    always_comb
    begin
        logic [15:0] ad;
        ad = d_reg[sel][15] ? 16'(~d_reg[sel] + 16'd1) : d_reg[sel];
        if (state_reg == S_XMUL)
        begin
            mul_a = (d_reg[sel] > 0) ? (17'h10000 - 17'(frac_reg[sel]))
                                     : 17'(frac_reg[sel]);
            mul_b = spc_reg[sel];
        end
        else
        begin
            mul_a = 17'(ad);
            mul_b = 32'(ad);
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 49'(mul_a) * 49'(mul_b);
    end

    // Square root digit step
    assign rt_sh = {rem_reg, sv_reg[33:32]};
    assign rt_t  = {2'b00, root_reg, 2'b01};
    assign rt_ge = (rt_sh >= rt_t);

    // Divider bit step
    assign den    = d_reg[ax_reg][15] ? 16'(~d_reg[ax_reg] + 16'd1) : d_reg[ax_reg];
    assign dv_sh  = {drem_reg, num_reg[31]};
    assign dv_ge  = (dv_sh >= {1'b0, den});
    assign dv_num = {num_reg[30:0], dv_ge};

    // Walk: grid test and axis choice
    assign in_grid = ((pos_reg[0] >> GRID_BITS) == '0)
                  && ((pos_reg[1] >> GRID_BITS) == '0)
                  && ((pos_reg[2] >> GRID_BITS) == '0);
    assign cell_hit = in_grid && row_reg[pos_reg[0][GRID_BITS-1:0]];

    always_comb
    begin
        if ((crs_reg[0] < crs_reg[1]) && (crs_reg[0] < crs_reg[2]))
            pick = 2'd0;
        else if (crs_reg[1] < crs_reg[2])
            pick = 2'd1;
        else
            pick = 2'd2;
    end

    assign crs_sum = 33'(crs_reg[pick]) + 33'(spc_reg[pick]);

    // Sequencer
    always_comb
    begin
        logic [31:0] acc_sum;
        logic        finish;
        logic        fhit;
        logic        up;
        logic [31:0] tnew;

        state_next = state_reg;
        d_next     = d_reg;
        frac_next  = frac_reg;
        pos_next   = pos_reg;
        spc_next   = spc_reg;
        crs_next   = crs_reg;
        limit_next = limit_reg;
        acc_next   = acc_reg;
        sv_next    = sv_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        len_next   = len_reg;
        num_next   = num_reg;
        drem_next  = drem_reg;
        cnt_next   = cnt_reg;
        ax_next    = ax_reg;
        trav_next  = trav_reg;
        face_next  = face_reg;
        clr_next   = clr_reg;
        done_next  = 1'b0;
        hit_next   = hit_reg;
        hx_next    = hx_reg;
        hy_next    = hy_reg;
        hz_next    = hz_reg;
        hf_next    = hf_reg;
        acc_sum    = acc_reg + prod_reg[31:0];
        finish     = 1'b0;
        fhit       = 1'b0;
        up         = 1'b0;
        tnew       = crs_reg[pick];

        case (state_reg)
            S_CLEAR:
            begin
                clr_next = ROW_W'(clr_reg + 1'b1);
                if (clr_reg == '1)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept && (op == OP_CAST))
                begin
                    d_next[0]    = dir_x;
                    d_next[1]    = dir_y;
                    d_next[2]    = dir_z;
                    frac_next[0] = origin_x[15:0];
                    frac_next[1] = origin_y[15:0];
                    frac_next[2] = origin_z[15:0];
                    pos_next[0]  = {{(POS_W-8){origin_x[23]}}, origin_x[23:16]};
                    pos_next[1]  = {{(POS_W-8){origin_y[23]}}, origin_y[23:16]};
                    pos_next[2]  = {{(POS_W-8){origin_z[23]}}, origin_z[23:16]};
                    limit_next   = max_dist;
                    acc_next     = '0;
                    cnt_next     = '0;
                    state_next   = S_SQ;
                end
            end
            S_SQ:
            begin
                // Accumulate the square issued last cycle
                if (cnt_reg != 5'd0)
                    acc_next = acc_sum;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd3)
                begin
                    if (acc_sum <= LEN_MIN_SQ)
                    begin
                        finish = 1'b1;
                    end
                    else
                    begin
                        sv_next    = {acc_sum, 2'b00};
                        rem_next   = '0;
                        root_next  = '0;
                        cnt_next   = '0;
                        state_next = S_SQRT;
                    end
                end
            end
            S_SQRT:
            begin
                // One result bit per cycle
                rem_next  = rt_ge ? 19'(rt_sh - rt_t) : rt_sh[18:0];
                root_next = {root_reg[15:0], rt_ge};
                sv_next   = {sv_reg[31:0], 2'b00};
                cnt_next  = cnt_reg + 5'd1;
                if (cnt_reg == 5'd16)
                begin
                    len_next   = {root_reg[15:0], rt_ge};
                    num_next   = {root_reg[15:0], rt_ge, 15'd0};
                    drem_next  = '0;
                    cnt_next   = '0;
                    ax_next    = 2'd0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (den == 16'd0)
                begin
                    spc_next[ax_reg] = T_INF;
                    up = 1'b1;
                end
                else
                begin
                    drem_next = dv_ge ? 16'(dv_sh - {1'b0, den}) : dv_sh[15:0];
                    num_next  = dv_num;
                    cnt_next  = cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31)
                    begin
                        spc_next[ax_reg] = dv_num;
                        up = 1'b1;
                    end
                end
                // Advance to the next axis, or to the first crossings after the last axis
                if (up)
                begin
                    num_next  = {len_reg, 15'd0};
                    drem_next = '0;
                    cnt_next  = '0;
                    if (ax_reg == 2'd2)
                        state_next = S_XMUL;
                    else
                        ax_next = ax_reg + 2'd1;
                end
            end
            S_XMUL:
            begin
                // First crossing per axis from the product of last cycle
                if (cnt_reg != 5'd0)
                begin
                    if ((d_reg[cm1] == 16'sd0) || prod_reg[48])
                        crs_next[cm1] = T_INF;
                    else
                        crs_next[cm1] = prod_reg[47:16];
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd3)
                begin
                    trav_next = '0;
                    face_next = FACE_START;
                    if (limit_reg == 16'd0)
                        finish = 1'b1;
                    else
                        state_next = S_WREAD;
                end
            end
            S_WREAD:
            begin
                state_next = S_WSTEP;
            end
            S_WSTEP:
            begin
                if (cell_hit)
                begin
                    finish = 1'b1;
                    fhit   = 1'b1;
                end
                else
                begin
                    // Step across the nearest boundary
                    trav_next = tnew;
                    crs_next[pick] = crs_sum[32] ? T_INF : crs_sum[31:0];
                    if (d_reg[pick] > 0)
                        pos_next[pick] = pos_reg[pick] + POS_W'(1);
                    else if (d_reg[pick] < 0)
                        pos_next[pick] = pos_reg[pick] - POS_W'(1);
                    case (pick)
                        2'd0:    face_next = (d_reg[0] > 0) ? FACE_PX : FACE_NX;
                        2'd1:    face_next = (d_reg[1] > 0) ? FACE_PY : FACE_NY;
                        default: face_next = (d_reg[2] > 0) ? FACE_PZ : FACE_NZ;
                    endcase
                    if (tnew < limit_q)
                        state_next = S_WREAD;
                    else
                        finish = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Drop the result on the output, with done high for one cycle
        if (finish)
        begin
            done_next  = 1'b1;
            hit_next   = fhit;
            hx_next    = fhit ? pos_reg[0][4:0] : 5'd0;
            hy_next    = fhit ? pos_reg[1][4:0] : 5'd0;
            hz_next    = fhit ? pos_reg[2][4:0] : 5'd0;
            hf_next    = fhit ? face_reg : FACE_START;
            state_next = S_IDLE;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            ax_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
            ax_reg    <= ax_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        d_reg     <= d_next;
        frac_reg  <= frac_next;
        pos_reg   <= pos_next;
        spc_reg   <= spc_next;
        crs_reg   <= crs_next;
        limit_reg <= limit_next;
        acc_reg   <= acc_next;
        sv_reg    <= sv_next;
        rem_reg   <= rem_next;
        root_reg  <= root_next;
        len_reg   <= len_next;
        num_reg   <= num_next;
        drem_reg  <= drem_next;
        trav_reg  <= trav_next;
        face_reg  <= face_next;
        hit_reg   <= hit_next;
        hx_reg    <= hx_next;
        hy_reg    <= hy_next;
        hz_reg    <= hz_next;
        hf_reg    <= hf_next;
    end

    assign done       = done_reg;
    assign hit_found  = hit_reg;
    assign hit_x      = hx_reg;
    assign hit_y      = hy_reg;
    assign hit_z      = hz_reg;
    assign entry_face = hf_reg;

    `VRT_ASSERT_IMP(a_done_idle, clk, rst_n, done, !busy)
    `VRT_ASSERT_NXT(a_cast_busy, clk, rst_n, start && !busy && (op == OP_CAST), busy)
    `VRT_ASSERT_IMP(a_miss_zero, clk, rst_n, done && !hit_found,
        (hit_x == 5'd0) && (hit_y == 5'd0) && (hit_z == 5'd0) && (entry_face == FACE_START))
    `VRT_ASSERT_NXT(a_write_free, clk, rst_n, start && !busy && (op == OP_WRITE), !busy && !done)

endmodule

FILE: sim/tb_voxel_ray_traversal.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_voxel_ray_traversal
// Self-checking bench for the voxel grid ray caster. A queue of write and
// cast requests feeds a falling-edge driver; each accepted cast is run
// through a bit-exact fixed-point walk predictor, and every done pulse is
// compared field by field against the oldest predicted hit record.
// ---------------------------------------------------------------------------
module tb_voxel_ray_traversal;
    import vrt_pkg::*;

    localparam int SIDE      = 1 << GRID_BITS;
    localparam int WDOG_MAX  = 20000;
    localparam int N_RANDOM  = 1030;

    typedef struct {
        logic               op;
        logic [4:0]         cx, cy, cz;
        logic               solid;
        logic signed [23:0] ox, oy, oz;
        logic signed [15:0] dx, dy, dz;
        logic [15:0]        md;
        int                 idle_pct;
        bit                 drain;
    } ray_req_t;

    typedef struct {
        logic       hit;
        logic [4:0] hx, hy, hz;
        logic [2:0] face;
    } hit_rec_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               op;
    logic [4:0]         cell_x, cell_y, cell_z;
    logic               solid;
    logic signed [23:0] origin_x, origin_y, origin_z;
    logic signed [15:0] dir_x, dir_y, dir_z;
    logic [15:0]        max_dist;
    logic               done;
    logic               hit_found;
    logic [4:0]         hit_x, hit_y, hit_z;
    logic [2:0]         entry_face;

    ray_req_t ray_req_q[$];
    hit_rec_t predicted_q[$];
    bit       occ_grid[SIDE*SIDE*SIDE];
    bit       req_taken;
    int       n_errors;
    int       n_writes, n_casts, n_hits;
    int       wdog;

    voxel_ray_traversal i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .op         (op),
        .cell_x     (cell_x),
        .cell_y     (cell_y),
        .cell_z     (cell_z),
        .solid      (solid),
        .origin_x   (origin_x),
        .origin_y   (origin_y),
        .origin_z   (origin_z),
        .dir_x      (dir_x),
        .dir_y      (dir_y),
        .dir_z      (dir_z),
        .max_dist   (max_dist),
        .done       (done),
        .hit_found  (hit_found),
        .hit_x      (hit_x),
        .hit_y      (hit_y),
        .hit_z      (hit_z),
        .entry_face (entry_face)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] ERROR %s: got %0d, predicted %0d", $realtime, what, got, want);
        n_errors++;
    endtask

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned sat_time(input longint unsigned v);
        return (v > T_INF) ? T_INF : v;
    endfunction

    function automatic bit cell_solid(input longint signed x, input longint signed y,
                                      input longint signed z);
        if (x < 0 || y < 0 || z < 0 || x >= SIDE || y >= SIDE || z >= SIDE)
            return 1'b0;
        return occ_grid[(z * SIDE + y) * SIDE + x];
    endfunction

    // Walk the grid in crossing order and return the first solid voxel, if any
    function automatic hit_rec_t cast_ray(input ray_req_t r);
        hit_rec_t        res;
        longint signed   dv[3];
        longint signed   ov[3];
        longint signed   pos[3];
        longint unsigned nxt[3];
        longint unsigned spc[3];
        int              stp[3];
        longint unsigned sq, len, lim, trav, frac, f, ad;
        logic [2:0]      face;
        int              ax;
        res = '{hit: 1'b0, hx: '0, hy: '0, hz: '0, face: FACE_START};
        dv[0] = r.dx; dv[1] = r.dy; dv[2] = r.dz;
        ov[0] = r.ox; ov[1] = r.oy; ov[2] = r.oz;
        sq = 0;
        for (int a = 0; a < 3; a++)
            sq += dv[a] * dv[a];
        if (sq <= LEN_MIN_SQ)
            return res;
        len = int_sqrt(sq * 4);
        for (int a = 0; a < 3; a++)
        begin
            frac   = ov[a] & 64'hFFFF;
            pos[a] = ov[a] >>> 16;
            stp[a] = (dv[a] > 0) ? 1 : ((dv[a] < 0) ? -1 : 0);
            ad     = (dv[a] < 0) ? -dv[a] : dv[a];
            if (ad == 0)
            begin
                spc[a] = T_INF;
                nxt[a] = T_INF;
            end
            else
            begin
                f      = (stp[a] > 0) ? 65536 - frac : frac;
                spc[a] = sat_time((len << 15) / ad);
                nxt[a] = sat_time((f * spc[a]) >> 16);
            end
        end
        trav = 0;
        face = FACE_START;
        lim  = longint'(r.md) << 8;
        while (trav < lim)
        begin
            if (cell_solid(pos[0], pos[1], pos[2]))
            begin
                res.hit  = 1'b1;
                res.hx   = pos[0][4:0];
                res.hy   = pos[1][4:0];
                res.hz   = pos[2][4:0];
                res.face = face;
                return res;
            end
            if (nxt[0] < nxt[1] && nxt[0] < nxt[2])
                ax = 0;
            else if (nxt[1] < nxt[2])
                ax = 1;
            else
                ax = 2;
            trav     = nxt[ax];
            nxt[ax]  = sat_time(nxt[ax] + spc[ax]);
            pos[ax] += stp[ax];
            case (ax)
                0: face = (stp[ax] > 0) ? FACE_PX : FACE_NX;
                1: face = (stp[ax] > 0) ? FACE_PY : FACE_NY;
                default: face = (stp[ax] > 0) ? FACE_PZ : FACE_NZ;
            endcase
        end
        return res;
    endfunction

    function automatic ray_req_t mk_write(input int x, input int y, input int z, input bit s);
        ray_req_t r;
        r       = '{default: '0};
        r.op    = OP_WRITE;
        r.cx    = 5'(x);
        r.cy    = 5'(y);
        r.cz    = 5'(z);
        r.solid = s;
        return r;
    endfunction

    function automatic ray_req_t mk_cast(input logic signed [23:0] ox, input logic signed [23:0] oy,
                                         input logic signed [23:0] oz, input int dx, input int dy,
                                         input int dz, input int md);
        ray_req_t r;
        r    = '{default: '0};
        r.op = OP_CAST;
        r.ox = ox; r.oy = oy; r.oz = oz;
        r.dx = 16'(dx); r.dy = 16'(dy); r.dz = 16'(dz);
        r.md = 16'(md);
        return r;
    endfunction

    // Voxel center in Q8.16
    function automatic logic signed [23:0] mid(input int v);
        return 24'((v <<< 16) + 32'sh8000);
    endfunction

    function automatic logic signed [15:0] rand_dir_axis();
        return 16'($urandom);
    endfunction

    function automatic logic signed [23:0] rand_origin();
        if ($urandom_range(0, 99) < 80)
            return 24'((($urandom_range(0, 37) - 3) <<< 16) | $urandom_range(0, 65535));
        return 24'($urandom);
    endfunction

    function automatic ray_req_t rand_req(input int idle_pct);
        ray_req_t r;
        int       k;
        r = '{default: '0};
        if ($urandom_range(0, 99) < 40)
        begin
            r       = mk_write($urandom_range(0, 31), $urandom_range(0, 31),
                               $urandom_range(0, 31), 1'b0);
            r.solid = ($urandom_range(0, 99) < 65);
            // noise on the cast-only fields
            r.ox = 24'($urandom); r.dx = 16'($urandom); r.md = 16'($urandom);
        end
        else
        begin
            r.op = OP_CAST;
            r.ox = rand_origin(); r.oy = rand_origin(); r.oz = rand_origin();
            r.cx = 5'($urandom); r.solid = 1'($urandom);
            k = $urandom_range(0, 9);
            r.dx = rand_dir_axis(); r.dy = rand_dir_axis(); r.dz = rand_dir_axis();
            if (k == 7)
            begin
                r.dy = 0;
                r.dz = 0;
            end
            else if (k == 8)
                r.dx = 0;
            else if (k == 9)
            begin
                r.dx = 16'($urandom_range(0, 6) - 3);
                r.dy = 16'($urandom_range(0, 6) - 3);
                r.dz = 16'($urandom_range(0, 6) - 3);
            end
            k = $urandom_range(0, 99);
            if (k < 85)
                r.md = 16'($urandom_range(0, 12800));
            else if (k < 95)
                r.md = 16'($urandom_range(0, 255));
            else
                r.md = 16'($urandom);
        end
        r.idle_pct = idle_pct;
        return r;
    endfunction

    // Hold a request until accepted, then present the next one or idle
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (!(start && !req_taken))
        begin
            if (ray_req_q.size() == 0)
                start <= 1'b0;
            else if (ray_req_q[0].drain && (predicted_q.size() != 0 || busy))
                start <= 1'b0;
            else if ($urandom_range(0, 99) < ray_req_q[0].idle_pct)
                start <= 1'b0;
            else
            begin
                start    <= 1'b1;
                op       <= ray_req_q[0].op;
                cell_x   <= ray_req_q[0].cx;
                cell_y   <= ray_req_q[0].cy;
                cell_z   <= ray_req_q[0].cz;
                solid    <= ray_req_q[0].solid;
                origin_x <= ray_req_q[0].ox;
                origin_y <= ray_req_q[0].oy;
                origin_z <= ray_req_q[0].oz;
                dir_x    <= ray_req_q[0].dx;
                dir_y    <= ray_req_q[0].dy;
                dir_z    <= ray_req_q[0].dz;
                max_dist <= ray_req_q[0].md;
            end
        end
    end

    // Take requests into the predictor and check each done pulse
    always @(posedge clk)
    begin
        ray_req_t r;
        hit_rec_t want;
        req_taken = 1'b0;
        if (rst_n)
        begin
            wdog++;
            if (start && !busy)
            begin
                req_taken = 1'b1;
                wdog      = 0;
                r         = ray_req_q.pop_front();
                if (r.op == OP_WRITE)
                begin
                    occ_grid[(int'(r.cz) * SIDE + int'(r.cy)) * SIDE + int'(r.cx)] = r.solid;
                    n_writes++;
                end
                else
                begin
                    predicted_q.push_back(cast_ray(r));
                    n_casts++;
                end
            end
            if (done)
            begin
                wdog = 0;
                if (predicted_q.size() == 0)
                    report_mismatch("unexpected done", 1, 0);
                else
                begin
                    want = predicted_q.pop_front();
                    n_hits += want.hit;
                    if (hit_found !== want.hit)
                        report_mismatch("hit_found", hit_found, want.hit);
                    if (hit_x !== want.hx)
                        report_mismatch("hit_x", hit_x, want.hx);
                    if (hit_y !== want.hy)
                        report_mismatch("hit_y", hit_y, want.hy);
                    if (hit_z !== want.hz)
                        report_mismatch("hit_z", hit_z, want.hz);
                    if (entry_face !== want.face)
                        report_mismatch("entry_face", entry_face, want.face);
                end
            end
            if (wdog >= WDOG_MAX)
            begin
                $display("[%0t] ERROR watchdog: no progress in %0d cycles", $realtime, wdog);
                $display("voxel_ray_traversal: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        ray_req_t r;
        int       pct;
        n_errors = 0; n_writes = 0; n_casts = 0; n_hits = 0; wdog = 0;
        rst_n = 1'b0; start = 1'b0; op = OP_WRITE;
        cell_x = '0; cell_y = '0; cell_z = '0; solid = 1'b0;
        origin_x = '0; origin_y = '0; origin_z = '0;
        dir_x = '0; dir_y = '0; dir_z = '0; max_dist = '0;
        foreach (occ_grid[i])
            occ_grid[i] = 1'b0;

        // Directed: solid targets around (5,5,5) and at two corners, then one cast per face
        ray_req_q.push_back(mk_write(0, 0, 0, 1'b1));
        ray_req_q.push_back(mk_write(31, 31, 31, 1'b1));
        ray_req_q.push_back(mk_write(10, 5, 5, 1'b1));
        ray_req_q.push_back(mk_write(5, 10, 5, 1'b1));
        ray_req_q.push_back(mk_write(5, 5, 10, 1'b1));
        ray_req_q.push_back(mk_write(5, 5, 0, 1'b1));
        ray_req_q.push_back(mk_cast(mid(5), mid(5), mid(5), 16384, 0, 0, 20 << 8));
        ray_req_q.push_back(mk_cast(mid(5), mid(5), mid(5), 0, 16384, 0, 20 << 8));
        ray_req_q.push_back(mk_cast(mid(5), mid(5), mid(5), 0, 0, 16384, 20 << 8));
        ray_req_q.push_back(mk_cast(mid(5), mid(5), mid(5), 0, 0, -16384, 20 << 8));
        ray_req_q.push_back(mk_cast(mid(12), mid(5), mid(5), -32768, 0, 0, 20 << 8));
        ray_req_q.push_back(mk_cast(mid(5), mid(12), mid(5), 0, -9000, 0, 20 << 8));
        // start voxel already solid
        ray_req_q.push_back(mk_cast(mid(0), mid(0), mid(0), 300, -200, 100, 5 << 8));
        // exact diagonal: crossings tie on all axes
        ray_req_q.push_back(mk_cast(24'(28 <<< 16), 24'(28 <<< 16), 24'(28 <<< 16),
                                    1000, 1000, 1000, 16'hFFFF));
        // zero direction, length at and just above the short limit
        ray_req_q.push_back(mk_cast(mid(5), mid(5), mid(5), 0, 0, 0, 16'hFFFF));
        ray_req_q.push_back(mk_cast(mid(9), mid(5), mid(5), 3, 1, 0, 16'hFFFF));
        ray_req_q.push_back(mk_cast(mid(9), mid(5), mid(5), 3, 1, 1, 16'hFFFF));
        // zero distance on a solid start voxel still misses
        ray_req_q.push_back(mk_cast(mid(10), mid(5), mid(5), 100, 0, 0, 0));
        // unit direction on the minor axis, giving it a very large spacing
        ray_req_q.push_back(mk_cast(mid(3), mid(5), mid(5), 32767, 1, 0, 16'hFFFF));
        // origin extremes, far outside the grid
        ray_req_q.push_back(mk_cast(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
                                    -32768, -32768, -32768, 16'hFFFF));
        ray_req_q.push_back(mk_cast(-24'sh800000, -24'sh800000, -24'sh800000,
                                    32767, 32767, 32767, 16'hFFFF));
        // clear a voxel and cast through it
        ray_req_q.push_back(mk_write(10, 5, 5, 1'b0));
        ray_req_q.push_back(mk_cast(mid(5), mid(5), mid(5), 16384, 0, 0, 40 << 8));
        ray_req_q[$].drain = 1'b1;

        // Random: idling phases none, sender 71%, none, sender 17%
        for (int i = 0; i < N_RANDOM; i++)
        begin
            case ((i * 4) / N_RANDOM)
                0: pct = 0;
                1: pct = 71;
                2: pct = 0;
                default: pct = 17;
            endcase
            r = rand_req(pct);
            if (i % (N_RANDOM / 4) == 0 || i % 97 == 50)
                r.drain = 1'b1;
            ray_req_q.push_back(r);
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (ray_req_q.size() == 0);
        wait (predicted_q.size() == 0);
        repeat (300) @(posedge clk);
        while (predicted_q.size() != 0)
        begin
            void'(predicted_q.pop_front());
            report_mismatch("cast with no done", 0, 1);
        end
        $display("Covered %0d voxel writes and %0d casts (%0d hits) over four idling phases.",
                 n_writes, n_casts, n_hits);
        if (n_errors == 0)
            $display("voxel_ray_traversal: match");
        else
            $display("voxel_ray_traversal: mismatch");
        $finish;
    end

endmodule
